[hdl/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/gkr_pkg.sv]
// types, constants and exp table builder for the kernel regression unit
package gkr_pkg;

    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 240;
    localparam int Q_DEPTH      = 2;
    localparam int EXP_BITS_MAX = 12;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [1:0] {
        OP_SUPPORT = 2'd0,
        OP_WEIGHT  = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_GAMMA     = 3'd0,
        CFG_ACT_SUP   = 3'd1,
        CFG_ACT_DIM   = 3'd2,
        CFG_CLAMP_LIM = 3'd3,
        CFG_CLAMP_EN  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIST,
        BK_GLO,
        BK_GHI,
        BK_KSUM,
        BK_YMUL,
        BK_KERN,
        BK_WMUL,
        BK_ACC,
        BK_ROUND,
        BK_ERR,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  support_index;
        logic [5:0]  dim_index;
        logic [31:0] value;
        logic [31:0] ref_force;
        logic        last;
        logic        si_ok;
        logic        di_ok;
    } cmd_t;

    typedef struct packed {
        logic [31:0] gamma;
        logic [8:0]  active_support;
        logic [6:0]  active_dim;
        logic [46:0] clamp_limit;
        logic        clamp_enable;
    } cfg_t;

    typedef struct packed {
        logic        clamped;
        logic [31:0] query_count;
        logic [47:0] error_max;
        logic [62:0] error_sum;
        logic [47:0] abs_error;
        logic [47:0] prediction;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic out_load;
        logic busy;
    } bk_stat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-idx/2^bits) in q1.32
    function automatic logic [32:0] exp_rom_value(input int bits, input int idx);
        logic [63:0] root [EXP_BITS_MAX];
        logic [63:0] p;
        int j;
        for (j = 0; j < EXP_BITS_MAX; j++) root[j] = 64'd0;
        root[bits-1] = isqrt64(64'd1 << 63);
        for (j = bits - 1; j > 0; j--) root[j-1] = isqrt64(root[j] << 32);
        p = 64'd1 << 32;
        for (j = 0; j < bits; j++) begin
            if (((idx >> j) & 1) != 0) begin
                p = (p * root[j]) >> 32;
            end
        end
        return p[32:0];
    endfunction

endpackage

[hdl/gkr_ram.sv]
// generic single-write, single-read ram with registered read data
module gkr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[hdl/gkr_front.sv]
// input side: unpacks transactions and checks store indexes
module gkr_front #(
    parameter int NUM_SUPPORT = 256,
    parameter int VEC_DIM     = 64
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gkr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,
    input  gkr_pkg::q_stat_t               q_stat,
    output logic                           push,
    output gkr_pkg::cmd_t                  cmd
);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        cmd.op            = gkr_pkg::op_t'(s_tuser);
        cmd.support_index = s_tdata[7:0];
        cmd.dim_index     = s_tdata[13:8];
        cmd.value         = s_tdata[45:14];
        cmd.ref_force     = s_tdata[77:46];
        cmd.last          = s_tlast;
        cmd.si_ok         = 32'(s_tdata[7:0]) < 32'(NUM_SUPPORT);
        cmd.di_ok         = 32'(s_tdata[13:8]) < 32'(VEC_DIM);
    end

endmodule

[hdl/gkr_queue.sv]
// short command queue between front and back
module gkr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gkr_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output gkr_pkg::cmd_t    head_cmd,
    output gkr_pkg::q_stat_t q_stat
);

    localparam int PW = $clog2(gkr_pkg::Q_DEPTH);
    localparam int CW = $clog2(gkr_pkg::Q_DEPTH + 1);

    gkr_pkg::cmd_t  slot_reg [gkr_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;

    assign q_stat.full  = count_reg == CW'(gkr_pkg::Q_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign head_cmd     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(gkr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(gkr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/gkr_back.sv]
// execution side: stores, distance mac, exp kernel, accumulation and statistics
module gkr_back #(
    parameter int NUM_SUPPORT    = 256,
    parameter int VEC_DIM        = 64,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  gkr_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    input  gkr_pkg::cfg_t     cfg,
    input  logic              m_ready,
    output logic              res_valid,
    output gkr_pkg::res_t     res,
    output gkr_pkg::bk_stat_t bk_stat
);

    localparam int SDEPTH   = NUM_SUPPORT * VEC_DIM;
    localparam int SAW      = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
    localparam int WAW      = NUM_SUPPORT > 1 ? $clog2(NUM_SUPPORT) : 1;
    localparam int QAW      = VEC_DIM > 1 ? $clog2(VEC_DIM) : 1;
    localparam int SCW      = $clog2(NUM_SUPPORT + 1);
    localparam int DCW      = $clog2(VEC_DIM + 1);
    localparam int ROM_SIZE = 1 << EXP_TABLE_BITS;

    gkr_pkg::bk_state_t state_reg, state_next;
    gkr_pkg::cmd_t      cur_reg;

    logic [SCW-1:0]     s_reg;
    logic [DCW-1:0]     d_reg;
    logic [SAW-1:0]     sbase_reg;
    logic [SAW-1:0]     sa_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        a_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        dist_reg;
    logic [63:0]        plo_reg;
    logic [63:0]        phi_reg;
    logic [19:0]        x_reg;
    logic               kzero_reg;
    logic [20:0]        y_reg;
    logic [16:0]        kern_reg;
    logic signed [49:0] wp_reg;
    logic signed [63:0] acc_reg;
    logic [47:0]        pred_reg;
    logic               clamped_reg;
    logic [47:0]        err_reg;
    logic [62:0]        sum_reg;
    logic [47:0]        max_reg;
    logic [31:0]        cnt_reg;
    logic               out_valid_reg;
    gkr_pkg::res_t      out_reg;

    logic [SCW-1:0]     ns;
    logic [DCW-1:0]     nd;
    logic               issue;
    logic               pipe_empty;
    logic               start_pred;
    logic               sup_we, wt_we, q_we, stat_clr, out_load;

    logic [31:0]        sup_rdata, wt_rdata, q_rdata;
    logic [32:0]        rom_w [ROM_SIZE];

    logic signed [32:0] diff33;
    logic [32:0]        mag33;
    logic [95:0]        psum;
    logic [36:0]        yprod;
    logic [4:0]         y_int;
    logic [EXP_TABLE_BITS-1:0] y_idx;
    logic [63:0]        ksum;
    logic [63:0]        kshift;
    logic [63:0]        rsum;
    logic [47:0]        pred_raw;
    logic [47:0]        pred_mag;
    logic               clamp_hit;
    logic [48:0]        d49;
    logic [48:0]        e49;
    logic [63:0]        sum64;
    logic [62:0]        new_sum;
    logic [47:0]        new_max;
    logic [31:0]        new_cnt;

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam logic [32:0] ROM_VAL = gkr_pkg::exp_rom_value(EXP_TABLE_BITS, g);
        assign rom_w[g] = ROM_VAL;
    end

    assign ns = ({23'd0, cfg.active_support} > 32'(NUM_SUPPORT))
        ? SCW'(NUM_SUPPORT) : SCW'(cfg.active_support);
    assign nd = ({25'd0, cfg.active_dim} > 32'(VEC_DIM))
        ? DCW'(VEC_DIM) : DCW'(cfg.active_dim);

    assign issue      = (state_reg == gkr_pkg::BK_DIST) && (d_reg < nd);
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign start_pred = (state_reg == gkr_pkg::BK_EXEC) && (cur_reg.op == gkr_pkg::OP_QUERY)
        && cur_reg.last;

    gkr_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_sup_ram (
        .aclk  (aclk),
        .we    (sup_we),
        .waddr (SAW'(32'(cur_reg.support_index) * 32'(VEC_DIM) + 32'(cur_reg.dim_index))),
        .wdata (cur_reg.value),
        .raddr (sa_reg),
        .rdata (sup_rdata)
    );

    gkr_ram #(.WIDTH(32), .DEPTH(NUM_SUPPORT)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (WAW'(cur_reg.support_index)),
        .wdata (cur_reg.value),
        .raddr (s_reg[WAW-1:0]),
        .rdata (wt_rdata)
    );

    gkr_ram #(.WIDTH(32), .DEPTH(VEC_DIM)) u_q_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (QAW'(cur_reg.dim_index)),
        .wdata (cur_reg.value),
        .raddr (d_reg[QAW-1:0]),
        .rdata (q_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gkr_pkg::BK_IDLE:  if (cmd_valid) state_next = gkr_pkg::BK_EXEC;
            gkr_pkg::BK_EXEC: begin
                if (start_pred) begin
                    state_next = (ns == '0) ? gkr_pkg::BK_ROUND : gkr_pkg::BK_DIST;
                end else begin
                    state_next = gkr_pkg::BK_IDLE;
                end
            end
            gkr_pkg::BK_DIST:  if (!issue && pipe_empty) state_next = gkr_pkg::BK_GLO;
            gkr_pkg::BK_GLO:   state_next = gkr_pkg::BK_GHI;
            gkr_pkg::BK_GHI:   state_next = gkr_pkg::BK_KSUM;
            gkr_pkg::BK_KSUM:  state_next = gkr_pkg::BK_YMUL;
            gkr_pkg::BK_YMUL:  state_next = gkr_pkg::BK_KERN;
            gkr_pkg::BK_KERN:  state_next = gkr_pkg::BK_WMUL;
            gkr_pkg::BK_WMUL:  state_next = gkr_pkg::BK_ACC;
            gkr_pkg::BK_ACC: begin
                state_next = (s_reg + SCW'(1) < ns) ? gkr_pkg::BK_DIST : gkr_pkg::BK_ROUND;
            end
            gkr_pkg::BK_ROUND: state_next = gkr_pkg::BK_ERR;
            gkr_pkg::BK_ERR:   state_next = gkr_pkg::BK_EMIT;
            gkr_pkg::BK_EMIT:  if (!out_valid_reg || m_ready) state_next = gkr_pkg::BK_IDLE;
            default:           state_next = gkr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop  = (state_reg == gkr_pkg::BK_IDLE) && cmd_valid;
        sup_we   = (state_reg == gkr_pkg::BK_EXEC) && (cur_reg.op == gkr_pkg::OP_SUPPORT)
            && cur_reg.si_ok && cur_reg.di_ok;
        wt_we    = (state_reg == gkr_pkg::BK_EXEC) && (cur_reg.op == gkr_pkg::OP_WEIGHT)
            && cur_reg.si_ok;
        q_we     = (state_reg == gkr_pkg::BK_EXEC) && (cur_reg.op == gkr_pkg::OP_QUERY)
            && cur_reg.di_ok;
        stat_clr = (state_reg == gkr_pkg::BK_EXEC) && (cur_reg.op == gkr_pkg::OP_CLEAR);
        out_load = (state_reg == gkr_pkg::BK_EMIT) && (!out_valid_reg || m_ready);
    end

    // datapath arithmetic
    always_comb begin
        diff33   = $signed({q_rdata[31], q_rdata}) - $signed({sup_rdata[31], sup_rdata});
        mag33    = diff33[32] ? 33'(-diff33) : 33'(diff33);
        psum     = {32'd0, plo_reg} + {phi_reg, 32'd0};
        yprod    = 37'(x_reg) * 37'(gkr_pkg::LOG2E_Q16);
        y_int    = y_reg[20:16];
        y_idx    = y_reg[15 -: EXP_TABLE_BITS];
        ksum     = 64'(rom_w[y_idx]) + (64'd1 << (6'(y_int) + 6'd15));
        kshift   = ksum >> (6'(y_int) + 6'd16);
        rsum     = 64'(acc_reg) + 64'd32768;
        pred_raw = rsum[63:16];
        pred_mag = pred_raw[47] ? 48'(-pred_raw) : pred_raw;
        clamp_hit = cfg.clamp_enable && (pred_mag > {1'b0, cfg.clamp_limit});
        d49      = {pred_reg[47], pred_reg} - {{17{cur_reg.ref_force[31]}}, cur_reg.ref_force};
        e49      = d49[48] ? 49'(-d49) : d49;
        sum64    = {1'b0, sum_reg} + {16'd0, err_reg};
        new_sum  = sum64[63] ? {63{1'b1}} : sum64[62:0];
        new_max  = (err_reg > max_reg) ? err_reg : max_reg;
        new_cnt  = (&cnt_reg) ? cnt_reg : cnt_reg + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gkr_pkg::BK_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            max_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (stat_clr) begin
                sum_reg <= '0;
                max_reg <= '0;
                cnt_reg <= '0;
            end else if (out_load) begin
                sum_reg <= new_sum;
                max_reg <= new_max;
                cnt_reg <= new_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cur_reg <= cmd;
        end
        if (start_pred) begin
            s_reg     <= '0;
            sbase_reg <= '0;
            sa_reg    <= '0;
            d_reg     <= '0;
            dist_reg  <= '0;
            acc_reg   <= '0;
        end else if (state_reg == gkr_pkg::BK_ACC) begin
            s_reg     <= s_reg + SCW'(1);
            sbase_reg <= sbase_reg + SAW'(VEC_DIM);
            sa_reg    <= sbase_reg + SAW'(VEC_DIM);
            d_reg     <= '0;
            dist_reg  <= '0;
            acc_reg   <= acc_reg + {{14{wp_reg[49]}}, wp_reg};
        end else begin
            if (issue) begin
                d_reg  <= d_reg + DCW'(1);
                sa_reg <= sa_reg + SAW'(1);
            end
            if (v3_reg) begin
                dist_reg <= dist_reg + {16'd0, sq_reg[63:16]};
            end
        end
        if (v1_reg) begin
            a_reg <= mag33[32] ? 32'hFFFF_FFFF : mag33[31:0];
        end
        if (v2_reg) begin
            sq_reg <= 64'(a_reg) * 64'(a_reg);
        end
        if (state_reg == gkr_pkg::BK_GLO) begin
            plo_reg <= 64'(cfg.gamma) * 64'(dist_reg[31:0]);
        end
        if (state_reg == gkr_pkg::BK_GHI) begin
            phi_reg <= 64'(cfg.gamma) * 64'(dist_reg[63:32]);
        end
        if (state_reg == gkr_pkg::BK_KSUM) begin
            kzero_reg <= (|psum[95:64]) || (|psum[63:36]);
            x_reg     <= psum[35:16];
        end
        if (state_reg == gkr_pkg::BK_YMUL) begin
            y_reg <= yprod[36:16];
        end
        if (state_reg == gkr_pkg::BK_KERN) begin
            kern_reg <= kzero_reg ? '0 : kshift[16:0];
        end
        if (state_reg == gkr_pkg::BK_WMUL) begin
            wp_reg <= $signed(wt_rdata) * $signed({1'b0, kern_reg});
        end
        if (state_reg == gkr_pkg::BK_ROUND) begin
            pred_reg    <= clamp_hit ? '0 : pred_raw;
            clamped_reg <= clamp_hit;
        end
        if (state_reg == gkr_pkg::BK_ERR) begin
            err_reg <= e49[48] ? {48{1'b1}} : e49[47:0];
        end
        if (out_load) begin
            out_reg.prediction  <= pred_reg;
            out_reg.abs_error   <= err_reg;
            out_reg.error_sum   <= new_sum;
            out_reg.error_max   <= new_max;
            out_reg.query_count <= new_cnt;
            out_reg.clamped     <= clamped_reg;
        end
    end

    assign res_valid        = out_valid_reg;
    assign res              = out_reg;
    assign bk_stat.out_load = out_load;
    assign bk_stat.busy     = state_reg != gkr_pkg::BK_IDLE;

endmodule

[hdl/gaussian_kernel_regression_predict_unit.sv]
// top level of the gaussian kernel regression inference unit
//
// channel  direction  tdata                                         tuser    tlast
// s_       in         support_index, dim_index, value, ref_force    op       last
// m_       out        prediction, abs_error, error_sum, error_max,  clamped  -
//                     query_count
// apb      in/out     registers at 8*i: gamma, active_support, active_dim,
//                     clamp_limit, clamp_enable
//
// load, clear and non-last query transactions go through IDLE and EXEC only in the execution side
// a last query element takes each support in use in turn through the DIST to ACC states
// of the single distance multiply-accumulate and kernel unit, then ROUND, ERR and EMIT
// a two-entry queue lets the input side accept up to two transactions while a result waits on m_tready
// reset clears control state and statistics; stores hold no value until written
`include "assert_macros.svh"

module gaussian_kernel_regression_predict_unit #(
    parameter int NUM_SUPPORT    = 256,
    parameter int VEC_DIM        = 64,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // support_index[7:0], dim_index[13:8], value[45:14], reference_force[77:46]
    input  logic [gkr_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // prediction[47:0], abs_error[95:48], error_sum[158:96], error_max[206:159],
    // query_count[238:207]
    output logic [gkr_pkg::M_TDATA_W-1:0] m_tdata,
    // clamped[0]
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    gkr_pkg::cfg_t     cfg_reg;
    gkr_pkg::cfg_idx_t cfg_idx;
    logic              cfg_we;

    gkr_pkg::cmd_t     f_cmd;
    gkr_pkg::cmd_t     q_head;
    gkr_pkg::q_stat_t  q_stat;
    logic              q_push;
    logic              bk_pop;
    gkr_pkg::res_t     bk_res;
    gkr_pkg::bk_stat_t bk_stat;

    assign pready  = 1'b1;
    assign cfg_idx = gkr_pkg::cfg_idx_t'(paddr[5:3]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gamma          <= 32'd65536;
            cfg_reg.active_support <= 9'd256;
            cfg_reg.active_dim     <= 7'd64;
            cfg_reg.clamp_limit    <= 47'd6553600;
            cfg_reg.clamp_enable   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                gkr_pkg::CFG_GAMMA:     cfg_reg.gamma          <= pwdata[31:0];
                gkr_pkg::CFG_ACT_SUP:   cfg_reg.active_support <= pwdata[8:0];
                gkr_pkg::CFG_ACT_DIM:   cfg_reg.active_dim     <= pwdata[6:0];
                gkr_pkg::CFG_CLAMP_LIM: cfg_reg.clamp_limit    <= pwdata[46:0];
                gkr_pkg::CFG_CLAMP_EN:  cfg_reg.clamp_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gkr_pkg::CFG_GAMMA:     prdata = 64'(cfg_reg.gamma);
            gkr_pkg::CFG_ACT_SUP:   prdata = 64'(cfg_reg.active_support);
            gkr_pkg::CFG_ACT_DIM:   prdata = 64'(cfg_reg.active_dim);
            gkr_pkg::CFG_CLAMP_LIM: prdata = 64'(cfg_reg.clamp_limit);
            gkr_pkg::CFG_CLAMP_EN:  prdata = 64'(cfg_reg.clamp_enable);
            default:                prdata = '0;
        endcase
    end

    gkr_front #(.NUM_SUPPORT(NUM_SUPPORT), .VEC_DIM(VEC_DIM)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (q_push),
        .cmd      (f_cmd)
    );

    gkr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (f_cmd),
        .pop      (bk_pop),
        .head_cmd (q_head),
        .q_stat   (q_stat)
    );

    gkr_back #(
        .NUM_SUPPORT    (NUM_SUPPORT),
        .VEC_DIM        (VEC_DIM),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!q_stat.empty),
        .cmd       (q_head),
        .cmd_pop   (bk_pop),
        .cfg       (cfg_reg),
        .m_ready   (m_tready),
        .res_valid (m_tvalid),
        .res       (bk_res),
        .bk_stat   (bk_stat)
    );

    assign m_tdata = {1'b0, bk_res.query_count, bk_res.error_max, bk_res.error_sum,
                      bk_res.abs_error, bk_res.prediction};
    assign m_tuser = bk_res.clamped;

    `ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, q_push, !q_stat.full)
    `ASSERT_IMPLIES(a_no_pop_empty, aclk, aresetn, bk_pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, bk_stat.out_load, !m_tvalid || m_tready)
    `ASSERT_NEXT(a_load_shows, aclk, aresetn, bk_stat.out_load, m_tvalid)

endmodule

[tb/gaussian_kernel_regression_predict_unit_tb.sv]
// self-checking testbench for the gaussian kernel regression inference unit
`timescale 1ns / 100ps

class kernel_regression_scoreboard;
    logic [31:0] support_mem [16384];
    logic [31:0] weight_mem [256];
    logic [31:0] query_vec [64];
    logic [63:0] exp_table [256];
    logic [63:0] err_sum;
    logic [47:0] err_max;
    logic [31:0] n_queries;
    logic [31:0] gamma;
    logic [8:0]  act_sup;
    logic [6:0]  act_dim;
    logic [46:0] clamp_lim;
    logic        clamp_en;
    gkr_pkg::res_t awaited [$];
    int          n_errors;
    int          n_checked;

    function new();
        logic [63:0] root [8];
        logic [63:0] p;
        err_sum = 0;
        err_max = 0;
        n_queries = 0;
        gamma = 32'd65536;
        act_sup = 9'd256;
        act_dim = 7'd64;
        clamp_lim = 47'd6553600;
        clamp_en = 1'b0;
        n_errors = 0;
        n_checked = 0;
        root[7] = floor_sqrt(64'd1 << 63);
        for (int j = 7; j > 0; j--) root[j-1] = floor_sqrt(root[j] << 32);
        for (int i = 0; i < 256; i++) begin
            p = 64'd1 << 32;
            for (int j = 0; j < 8; j++)
                if (i[j]) p = (p * root[j]) >> 32;
            exp_table[i] = p;
        end
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function logic [63:0] gauss(logic [63:0] sq_dist);
        logic [127:0] gd;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  n;
        gd = {64'd0, gamma} * {64'd0, sq_dist};
        if (gd[127:64] != 0) return 0;
        x = gd[63:0] >> 16;
        if (x >= (64'd16 << 16)) return 0;
        y = (x * 64'd94548) >> 16;
        n = y >> 16;
        return (exp_table[y[15:8]] + (64'd1 << (n + 15))) >> (n + 16);
    endfunction

    function longint predict();
        int     ns;
        int     nd;
        longint acc;
        longint df;
        logic [63:0] a;
        logic [63:0] sq_dist;
        ns = (act_sup > 256) ? 256 : act_sup;
        nd = (act_dim > 64) ? 64 : act_dim;
        acc = 0;
        for (int s = 0; s < ns; s++) begin
            sq_dist = 0;
            for (int d = 0; d < nd; d++) begin
                df = longint'($signed(query_vec[d])) - longint'($signed(support_mem[s*64+d]));
                a = (df < 0) ? -df : df;
                sq_dist += (a * a) >> 16;
            end
            acc += longint'($signed(weight_mem[s])) * longint'(gauss(sq_dist));
        end
        acc = (acc + 32768) >>> 16;
        if (acc > 64'sh7FFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF;
        if (acc < -64'sh8000_0000_0000) acc = -64'sh8000_0000_0000;
        return acc;
    endfunction

    function void note_input(gkr_pkg::op_t op, logic [7:0] si, logic [5:0] di,
                             logic [31:0] val, logic [31:0] rf, logic last);
        longint pred;
        longint diff;
        logic [63:0] e;
        gkr_pkg::res_t r;
        case (op)
            gkr_pkg::OP_CLEAR: begin
                err_sum = 0;
                err_max = 0;
                n_queries = 0;
            end
            gkr_pkg::OP_SUPPORT: support_mem[{si, di}] = val;
            gkr_pkg::OP_WEIGHT:  weight_mem[si] = val;
            gkr_pkg::OP_QUERY: begin
                query_vec[di] = val;
                if (last) begin
                    pred = predict();
                    r.clamped = 1'b0;
                    if (clamp_en && ((pred < 0) ? -pred : pred) > longint'(clamp_lim)) begin
                        pred = 0;
                        r.clamped = 1'b1;
                    end
                    diff = pred - longint'($signed(rf));
                    e = (diff < 0) ? -diff : diff;
                    if (e > 64'hFFFF_FFFF_FFFF) e = 64'hFFFF_FFFF_FFFF;
                    err_sum += e;
                    if (err_sum > 64'h7FFF_FFFF_FFFF_FFFF) err_sum = 64'h7FFF_FFFF_FFFF_FFFF;
                    if (e[47:0] > err_max) err_max = e[47:0];
                    if (n_queries != 32'hFFFF_FFFF) n_queries++;
                    r.prediction = pred[47:0];
                    r.abs_error = e[47:0];
                    r.error_sum = err_sum[62:0];
                    r.error_max = err_max;
                    r.query_count = n_queries;
                    awaited = {awaited, r};
                end
            end
        endcase
    endfunction

    function void check_result(gkr_pkg::res_t got);
        gkr_pkg::res_t w;
        if (awaited.size() == 0) begin
            $error("result transaction with nothing expected");
            n_errors++;
            return;
        end
        w = awaited.pop_front();
        n_checked++;
        if (got.prediction !== w.prediction) begin
            $error("prediction expected %h got %h", w.prediction, got.prediction);
            n_errors++;
        end
        if (got.abs_error !== w.abs_error) begin
            $error("abs_error expected %h got %h", w.abs_error, got.abs_error);
            n_errors++;
        end
        if (got.error_sum !== w.error_sum) begin
            $error("error_sum expected %h got %h", w.error_sum, got.error_sum);
            n_errors++;
        end
        if (got.error_max !== w.error_max) begin
            $error("error_max expected %h got %h", w.error_max, got.error_max);
            n_errors++;
        end
        if (got.query_count !== w.query_count) begin
            $error("query_count expected %h got %h", w.query_count, got.query_count);
            n_errors++;
        end
        if (got.clamped !== w.clamped) begin
            $error("clamped expected %b got %b", w.clamped, got.clamped);
            n_errors++;
        end
    endfunction
endclass

module gaussian_kernel_regression_predict_unit_tb;
    localparam int CYCLE_LIMIT = 3000000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gkr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]                    s_tuser = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gkr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [5:0]                    paddr = '0;
    logic [63:0]                   pwdata = '0;
    logic [63:0]                   prdata;
    logic                          pready;

    kernel_regression_scoreboard sb = new();
    int  tx_gap_pct = 8;
    int  rx_stall_pct = 75;
    bit  rx_hold = 1'b0;
    int  cycles = 0;
    int  n_items = 0;
    int  n_loads = 0;
    int  q_sup = 4;
    int  q_dim = 4;

    gaussian_kernel_regression_predict_unit uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(gkr_pkg::res_t'({m_tuser, m_tdata[238:0]}));

    initial forever begin
        wait (rx_hold);
        repeat (3000) @(negedge aclk);
        rx_hold = 1'b0;
    end

    task automatic put_item(gkr_pkg::op_t op, logic [7:0] si, logic [5:0] di, logic [31:0] val,
                            logic [31:0] rf, logic last);
        if ($urandom_range(99) < tx_gap_pct) repeat ($urandom_range(1, 4)) @(negedge aclk);
        s_tdata = {2'b00, rf, val, di, si};
        s_tuser = op;
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, si, di, val, rf, last);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(gkr_pkg::cfg_idx_t idx, logic [63:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            gkr_pkg::CFG_GAMMA:     sb.gamma = val[31:0];
            gkr_pkg::CFG_ACT_SUP:   sb.act_sup = val[8:0];
            gkr_pkg::CFG_ACT_DIM:   sb.act_dim = val[6:0];
            gkr_pkg::CFG_CLAMP_LIM: sb.clamp_lim = val[46:0];
            gkr_pkg::CFG_CLAMP_EN:  sb.clamp_en = val[0];
        endcase
    endtask

    task automatic drain();
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_shape(int ns, int nd, logic [31:0] g);
        drain();
        write_reg(gkr_pkg::CFG_ACT_SUP, ns);
        write_reg(gkr_pkg::CFG_ACT_DIM, nd);
        write_reg(gkr_pkg::CFG_GAMMA, g);
        q_sup = (ns == 0) ? 1 : ((ns > 256) ? 256 : ns);
        q_dim = (nd == 0) ? 1 : ((nd > 64) ? 64 : nd);
    endtask

    function automatic logic [31:0] small_val();
        return $urandom_range(0, 4 * 65536) - 2 * 65536;
    endfunction

    function automatic logic [31:0] any_val();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return small_val();
        endcase
    endfunction

    task automatic query(int len, logic [31:0] rf);
        for (int d = 0; d < len; d++)
            put_item(gkr_pkg::OP_QUERY, $urandom_range(255), d, any_val(), rf, d == len - 1);
    endtask

    task automatic random_chunk(int count);
        int target;
        int len;
        target = n_items + count;
        while (n_items < target) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    query(q_dim, any_val());
                    n_items += q_dim - 1;
                end
                10: begin
                    len = $urandom_range(1, q_dim);
                    query(len, $urandom());
                    n_items += len - 1;
                end
                11, 12, 13, 14:
                    put_item(gkr_pkg::OP_SUPPORT, $urandom_range(q_sup - 1),
                             $urandom_range(q_dim - 1), any_val(), $urandom(),
                             $urandom_range(1));
                15, 16:
                    put_item(gkr_pkg::OP_WEIGHT, $urandom_range(q_sup - 1), $urandom(),
                             any_val(), $urandom(), $urandom_range(1));
                17:
                    put_item(gkr_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom_range(1));
                default:
                    put_item(gkr_pkg::OP_QUERY, $urandom(), $urandom(), any_val(), $urandom(),
                             1'b0);
            endcase
            n_items++;
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // fill the store entries that later queries read
        for (int s = 0; s < 8; s++) begin
            put_item(gkr_pkg::OP_WEIGHT, s, 0, small_val(), 0, 1'b0);
            for (int d = 0; d < 8; d++)
                put_item(gkr_pkg::OP_SUPPORT, s, d, small_val(), 0, 1'b0);
        end
        for (int s = 0; s < 2; s++)
            for (int d = 8; d < 64; d++)
                put_item(gkr_pkg::OP_SUPPORT, s, d, small_val(), 0, 1'b0);
        for (int d = 0; d < 64; d++) put_item(gkr_pkg::OP_QUERY, 0, d, small_val(), 0, 1'b0);
        n_loads = 8 * 9 + 2 * 56 + 64;

        // directed corners
        set_shape(4, 4, 32'd65536);
        write_reg(gkr_pkg::CFG_CLAMP_LIM, 64'd6553600);
        write_reg(gkr_pkg::CFG_CLAMP_EN, 64'd0);
        put_item(gkr_pkg::OP_SUPPORT, 8'd0, 6'd0, 32'h8000_0000, 0, 1'b0);
        put_item(gkr_pkg::OP_SUPPORT, 8'd255, 6'd63, 32'h7FFF_FFFF, 0, 1'b0);
        put_item(gkr_pkg::OP_WEIGHT, 8'd0, 6'd0, 32'h7FFF_FFFF, 0, 1'b0);
        put_item(gkr_pkg::OP_WEIGHT, 8'd1, 6'd0, 32'h8000_0000, 0, 1'b0);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd1, 32'h0, 32'h8000_0000, 1'b1);
        put_item(gkr_pkg::OP_QUERY, 8'd255, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd2, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1);
        put_item(gkr_pkg::OP_CLEAR, 8'd0, 6'd0, 32'h0, 0, 1'b0);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd3, 32'hFFFF_0000, 32'h0, 1'b1);
        set_shape(4, 4, 32'd0);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd0, 32'h0, 32'h0, 1'b1);
        drain();
        write_reg(gkr_pkg::CFG_CLAMP_LIM, 64'd0);
        write_reg(gkr_pkg::CFG_CLAMP_EN, 64'd1);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd0, 32'h0, 32'h0001_0000, 1'b1);
        set_shape(0, 0, 32'hFFFF_FFFF);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd0, 32'h1234_5678, 32'h8000_0000, 1'b1);
        set_shape(8, 2, 32'hFFFF_FFFF);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd0, 32'h0, 32'h7FFF_FFFF, 1'b1);
        set_shape(2, 100, 32'd1);
        write_reg(gkr_pkg::CFG_CLAMP_LIM, 64'h7FFF_FFFF_FFFF);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd5, 32'h0, 32'h0, 1'b1);
        set_shape(8, 8, 32'd4);
        put_item(gkr_pkg::OP_QUERY, 8'd0, 6'd7, 32'h0002_0000, 32'h0, 1'b1);

        // random part under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            tx_gap_pct = (mode == 0) ? 8 : ((mode == 1) ? 75 : 0);
            rx_stall_pct = (mode == 0) ? 75 : ((mode == 1) ? 8 : 0);
            for (int k = 0; k < 3; k++) begin
                set_shape($urandom_range(1, 8), $urandom_range(1, 8),
                          $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(256, 131072));
                write_reg(gkr_pkg::CFG_CLAMP_EN, $urandom_range(1));
                write_reg(gkr_pkg::CFG_CLAMP_LIM,
                          {$urandom_range(15), $urandom()} & 64'h7FFF_FFFF_FFFF);
                if (mode == 2 && k == 0) begin
                    set_shape(2, 2, 32'd65536);
                    rx_hold = 1'b1;
                    for (int j = 0; j < 12; j++) query(2, small_val());
                    n_items += 24;
                    drain();
                end
                random_chunk(25);
            end
        end

        drain();
        $display("checked %0d predictions over %0d random items after %0d store loads",
                 sb.n_checked, n_items, n_loads);
        $display("idling patterns, stalled receiver, clamp, gamma and size corners covered");
        if (sb.n_errors == 0 && sb.awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
